// ----- design/ttqs_pkg.sv -----
// Package for the timed transmit queue scheduler.
// Holds table geometry, function codes, controller states and the entry struct.
package ttqs_pkg;
   localparam int ENTRIES = 16;
   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int TIME_W  = 48;
   localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

   localparam logic [2:0] FUNC_ADD     = 3'd0;
   localparam logic [2:0] FUNC_RESCHED = 3'd1;
   localparam logic [2:0] FUNC_SELECT  = 3'd2;
   localparam logic [2:0] FUNC_BUSY    = 3'd3;
   localparam logic [2:0] FUNC_RELEASE = 3'd4;

   localparam logic [1:0] REG_MAX_RESCHED = 2'd0;
   localparam logic [1:0] REG_MAX_DELAY   = 2'd1;
   localparam logic [1:0] REG_ACT_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_APPLY, ST_DONE
   } state_type;

   // one entry as it circulates around the ring of cells
   typedef struct packed {
      logic              valid;
      logic              busy;
      logic              important;
      logic              forced;
      logic [7:0]        tag;
      logic [7:0]        length;
      logic [15:0]       timeslot;
      logic [TIME_W-1:0] orig_time;
      logic [TIME_W-1:0] cur_time;
      logic [4:0]        resched;
      logic [SLOT_W-1:0] slot;
   } entry_type;
endpackage

// ----- design/ttqs_cell.sv -----
// One storage cell of the rotating entry ring.
// Depends on ttqs_pkg; passes its entry to the next cell each rotate cycle.
module ttqs_cell
   import ttqs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic [SLOT_W-1:0] init_slot,
   input  entry_type         prev_entry,
   output entry_type         entry
);
   entry_type entry_ff;
   logic valid_ff, busy_ff;
   logic [SLOT_W-1:0] slot_ff;

   always_ff @(posedge clock) begin
      if (shift) entry_ff <= prev_entry;
   end

   // the slot label travels with the entry; reset puts each label back home
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         slot_ff  <= init_slot;
      end else if (shift) begin
         valid_ff <= prev_entry.valid;
         busy_ff  <= prev_entry.busy;
         slot_ff  <= prev_entry.slot;
      end
   end

   always_comb begin
      entry = entry_ff;
      entry.valid = valid_ff;
      entry.busy  = busy_ff;
      entry.slot  = slot_ff;
   end
endmodule

// ----- design/timed_tx_queue_scheduler.sv -----
// Timed transmit queue scheduler: ring of ENTRIES cells plus a sequencer.
// Depends on ttqs_pkg and ttqs_cell.
// A request makes two passes around the cell ring, a scan pass and then an apply pass,
// one cell visited per cycle; busy is high until the result, so no new word is taken before it.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset clears all valid and busy bits and the control state at once.
module timed_tx_queue_scheduler
   import ttqs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_func,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic [TIME_W-1:0]        req_channel_free_ms,
   input  logic signed [TIME_W-1:0] req_time_arg,
   input  logic [7:0]               req_payload_length,
   input  logic                     req_is_important,
   input  logic                     req_is_forced,
   input  logic [7:0]               req_callback_tag,
   input  logic [15:0]              req_timeslot_ms,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [3:0]               rsp_slot,
   output logic                     rsp_chosen_forced,
   output logic [7:0]               rsp_chosen_length,
   output logic [7:0]               rsp_chosen_tag,
   output logic [15:0]              rsp_chosen_timeslot,
   output logic                     rsp_restart_radio,
   output logic [4:0]               rsp_entry_count,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   localparam int PASS_W = $clog2(ENTRIES);
   localparam logic [PASS_W-1:0] LAST = PASS_W'(ENTRIES - 1);

   // ---------------- configuration ----------------
   logic [4:0]  max_resched_ff;
   logic [23:0] max_delay_ff, act_timeout_ff;
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_resched_ff <= 5'd20;
         max_delay_ff   <= 24'd300000;
         act_timeout_ff <= 24'd180000;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_MAX_RESCHED: max_resched_ff <= pwdata[4:0];
            REG_MAX_DELAY:   max_delay_ff   <= pwdata[23:0];
            REG_ACT_TIMEOUT: act_timeout_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (paddr[3:2])
         REG_MAX_RESCHED: prdata = {27'd0, max_resched_ff};
         REG_MAX_DELAY:   prdata = {8'd0, max_delay_ff};
         REG_ACT_TIMEOUT: prdata = {8'd0, act_timeout_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // ---------------- ring of cells ----------------
   entry_type cell_q [ENTRIES];
   entry_type head_in;
   logic      shift;
   entry_type head;
   assign head = cell_q[ENTRIES-1];

   // cell g starts with slot ENTRIES-1-g, so the head sees slots in ascending order
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      entry_type prev;
      if (g == 0) begin : g_head
         assign prev = head_in;
      end else begin : g_link
         assign prev = cell_q[g-1];
      end
      ttqs_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .init_slot(SLOT_W'(ENTRIES - 1 - g)),
         .prev_entry(prev), .entry(cell_q[g])
      );
   end

   // ---------------- request capture ----------------
   logic [2:0]               func_ff;
   logic [TIME_W-1:0]        now_ff, cf_ff;
   logic signed [TIME_W-1:0] arg_ff;
   logic [7:0]               len_ff, tag_ff;
   logic                     imp_ff, frc_ff;
   logic [15:0]              ts_ff;

   state_type state_ff, state_in;
   logic [PASS_W-1:0] idx_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ongoing_ff;
   logic [SLOT_W-1:0] ongoing_slot_ff;
   logic [TIME_W-1:0] last_act_ff;

   // scan results
   logic              free_found_ff;
   logic [SLOT_W-1:0] free_slot_ff;
   logic [TIME_W-1:0] hi_ff, next_ff;
   logic              pick_found_ff;
   logic [SLOT_W-1:0] pick_ff;
   logic [TIME_W-1:0] pick_time_ff;
   logic              pick_forced_ff;
   logic [7:0]        pick_len_ff, pick_tag_ff;
   logic [15:0]       pick_ts_ff;
   logic              drop_ff;
   // effective operation in apply pass
   logic              do_resched_ff;
   logic signed [TIME_W:0] delta_ff;
   logic [TIME_W-1:0] mag_ff;
   logic [TIME_W-1:0] add_time_ff;
   logic              rst_radio_ff;

   wire accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func; now_ff <= req_now_ms; cf_ff <= req_channel_free_ms;
         arg_ff <= req_time_arg; len_ff <= req_payload_length; tag_ff <= req_callback_tag;
         imp_ff <= req_is_important; frc_ff <= req_is_forced; ts_ff <= req_timeslot_ms;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (idx_ff == LAST) state_in = ST_APPLY;
         ST_APPLY: if (idx_ff == LAST) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);

   // ---------------- per-cell arithmetic on the head ----------------
   logic signed [TIME_W+1:0] cf_s, now_s, cur_s, c_s, orig_s;
   logic signed [TIME_W+1:0] maxdiff_s;
   logic                     head_busy;
   logic                     elig;
   logic [TIME_W-1:0]        c_new;
   logic [4:0]               rs_new;
   logic                     drop_now;
   always_comb begin
      cf_s = {2'b00, cf_ff};
      now_s = {2'b00, now_ff};
      cur_s = {2'b00, head.cur_time};
      orig_s = {2'b00, head.orig_time};
      maxdiff_s = cf_s - {2'b00, next_ff};
      // a busy-channel word frees the ongoing entry before it reschedules
      head_busy = head.busy &&
                  !(func_ff == FUNC_BUSY && ongoing_ff && head.slot == ongoing_slot_ff);
      elig = head.valid && !head_busy && !head.forced;
      rs_new = (head.resched < 5'd31) ? head.resched + 5'd1 : head.resched;
      c_s = cur_s;
      if (!delta_ff[TIME_W]) c_s = cur_s + {{1{delta_ff[TIME_W]}}, delta_ff};
      else if (cur_s < cf_s - {{1{delta_ff[TIME_W]}}, delta_ff})
         c_s = cur_s + maxdiff_s - {{1{delta_ff[TIME_W]}}, delta_ff};
      if (c_s < now_s) c_s = now_s + {2'b00, mag_ff};
      if (c_s < 0) c_new = '0;
      else if (c_s > {2'b00, TMAX}) c_new = TMAX;
      else c_new = c_s[TIME_W-1:0];
      drop_now = !head.important &&
                 ((rs_new > max_resched_ff) ||
                  ({2'b00, c_new} - orig_s > {26'd0, max_delay_ff}));
   end

   // head_in: rewritten entry fed back into the ring
   always_comb begin
      head_in = head;
      if (state_ff == ST_APPLY) begin
         if (func_ff == FUNC_ADD && free_found_ff && head.slot == free_slot_ff) begin
            head_in.valid = 1'b1; head_in.busy = 1'b0;
            head_in.length = len_ff; head_in.important = imp_ff; head_in.forced = frc_ff;
            head_in.tag = tag_ff; head_in.timeslot = ts_ff;
            head_in.orig_time = add_time_ff; head_in.cur_time = add_time_ff;
            head_in.resched = 5'd0;
         end
         if (rst_radio_ff && head.slot == ongoing_slot_ff) head_in.busy = 1'b0;
         if ((func_ff == FUNC_BUSY || func_ff == FUNC_RELEASE) && ongoing_ff &&
             head.slot == ongoing_slot_ff) begin
            head_in.busy = 1'b0;
            if (func_ff == FUNC_RELEASE) begin
               head_in.valid = 1'b0; head_in.length = 8'd0;
            end
         end
         if (func_ff == FUNC_SELECT && !ongoing_ff && pick_found_ff && head.slot == pick_ff)
            head_in.busy = 1'b1;
         if (do_resched_ff && elig) begin
            head_in.resched = rs_new;
            head_in.cur_time = c_new;
            if (drop_now) begin
               head_in.valid = 1'b0; head_in.length = 8'd0; head_in.busy = 1'b0;
            end
         end
      end
   end

   wire sel_cand = head.valid && (head.cur_time <= now_ff);

   // latest time seen so far, including the entry at the head
   logic [TIME_W-1:0] hi_now;
   assign hi_now = (head.valid && head.cur_time > hi_ff) ? head.cur_time : hi_ff;

   logic signed [TIME_W+1:0] add_t;
   always_comb begin
      if (arg_ff == 0) add_t = (cf_ff < now_ff) ? {2'b00, now_ff} : {2'b00, cf_ff};
      else if (arg_ff[TIME_W-1]) add_t = {2'b00, hi_now} - {{2{arg_ff[TIME_W-1]}}, arg_ff};
      else add_t = {2'b00, arg_ff};
   end

   logic signed [TIME_W:0] bdelta;
   assign bdelta = {1'b0, cf_ff} - {1'b0, now_ff};

   // time since the last select; a negative gap never times out
   logic signed [TIME_W+1:0] idle_s;
   assign idle_s = {2'b00, now_ff} - {2'b00, last_act_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; idx_ff <= '0; count_ff <= '0;
         ongoing_ff <= 1'b0; ongoing_slot_ff <= '0; last_act_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= 1'b0;
         if (shift) idx_ff <= idx_ff + PASS_W'(1);
         if (state_ff == ST_IDLE && start) begin
            idx_ff <= '0;
            free_found_ff <= 1'b0; pick_found_ff <= 1'b0; drop_ff <= 1'b0;
            hi_ff <= req_channel_free_ms; next_ff <= req_channel_free_ms;
            rst_radio_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN) begin
            if (!head.valid && (!free_found_ff || head.slot < free_slot_ff)) begin
               free_found_ff <= 1'b1; free_slot_ff <= head.slot;
            end
            hi_ff <= hi_now;
            if (elig && head.cur_time < next_ff) next_ff <= head.cur_time;
            // fold in ascending slot order: an earlier time or a forced entry takes over
            if (sel_cand &&
                (!pick_found_ff || head.forced || head.cur_time < pick_time_ff)) begin
               pick_found_ff <= 1'b1; pick_ff <= head.slot;
               pick_time_ff <= head.cur_time; pick_forced_ff <= head.forced;
               pick_len_ff <= head.length; pick_tag_ff <= head.tag;
               pick_ts_ff <= head.timeslot;
            end
            if (idx_ff == LAST) begin
               if (add_t > {2'b00, TMAX}) add_time_ff <= TMAX;
               else add_time_ff <= add_t[TIME_W-1:0];
               do_resched_ff <= (func_ff == FUNC_RESCHED) ||
                                (func_ff == FUNC_BUSY && !bdelta[TIME_W] && bdelta != 0);
               if (func_ff == FUNC_BUSY) begin
                  delta_ff <= bdelta; mag_ff <= bdelta[TIME_W-1:0];
               end else begin
                  delta_ff <= (arg_ff != 0) ? {arg_ff[TIME_W-1], arg_ff} :
                              (bdelta[TIME_W] ? '0 : bdelta);
                  mag_ff <= arg_ff[TIME_W-1] ? TIME_W'(-arg_ff) : arg_ff;
               end
               if (func_ff == FUNC_SELECT && ongoing_ff && !idle_s[TIME_W+1] &&
                   (idle_s > {26'd0, act_timeout_ff}))
                  rst_radio_ff <= 1'b1;
            end
         end
         if (state_ff == ST_APPLY && do_resched_ff && elig && drop_now) drop_ff <= 1'b1;
         if (state_ff == ST_DONE) begin
            rsp_valid <= 1'b1;
            count_ff <= count_in;
            unique case (func_ff) inside
               FUNC_SELECT:
                  if (ongoing_ff) begin
                     if (rst_radio_ff) ongoing_ff <= 1'b0;
                  end else begin
                     last_act_ff <= now_ff;
                     if (pick_found_ff) begin
                        ongoing_ff <= 1'b1; ongoing_slot_ff <= pick_ff;
                     end
                  end
               FUNC_BUSY, FUNC_RELEASE: ongoing_ff <= 1'b0;
               default: ;
            endcase
         end
      end
   end

   // release needs to know whether the ongoing slot was still valid
   logic rel_valid_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) rel_valid_ff <= 1'b0;
      else if (state_ff == ST_SCAN && head.valid && head.slot == ongoing_slot_ff)
         rel_valid_ff <= 1'b1;
   end

   // drop counting: one per dropped entry
   logic [CNT_W-1:0] drops_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) drops_ff <= '0;
      else if (state_ff == ST_APPLY && do_resched_ff && elig && drop_now)
         drops_ff <= drops_ff + CNT_W'(1);
   end

   logic ok_v;
   logic [SLOT_W-1:0] slot_v;
   always_comb begin
      count_in = count_ff;
      ok_v = 1'b0; slot_v = '0;
      unique case (func_ff) inside
         FUNC_ADD: if (free_found_ff) begin
            ok_v = 1'b1; slot_v = free_slot_ff; count_in = count_ff + CNT_W'(1);
         end
         FUNC_RESCHED, FUNC_BUSY: begin
            ok_v = drop_ff;
            count_in = (drops_ff > count_ff) ? '0 : count_ff - drops_ff;
         end
         FUNC_SELECT: if (!ongoing_ff && pick_found_ff) begin
            ok_v = 1'b1; slot_v = pick_ff;
         end
         FUNC_RELEASE: if (ongoing_ff && rel_valid_ff) begin
            ok_v = 1'b1; slot_v = ongoing_slot_ff;
            count_in = (count_ff != 0) ? count_ff - CNT_W'(1) : count_ff;
         end
         default: ;
      endcase
   end

   wire chose = (func_ff == FUNC_SELECT) && !ongoing_ff && pick_found_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_ok <= ok_v;
         rsp_slot <= 4'(slot_v);
         rsp_chosen_forced <= chose & pick_forced_ff;
         rsp_chosen_length <= chose ? pick_len_ff : 8'd0;
         rsp_chosen_tag <= chose ? pick_tag_ff : 8'd0;
         rsp_chosen_timeslot <= chose ? pick_ts_ff : 16'd0;
         rsp_restart_radio <= (func_ff == FUNC_SELECT) && rst_radio_ff;
         rsp_entry_count <= 5'(count_in);
      end
   end

   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid)
      else $error("result strobe missing");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("strobe longer than one cycle");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count out of range");
endmodule
